/* src/rwcp_pkg.sv */
`timescale 1ns / 1ps

package rwcp_pkg;

    // Chunk IDs as they read when assembled little-endian.
    localparam logic [31:0] ID_RIFF = 32'h4646_4952;
    localparam logic [31:0] ID_FMT  = 32'h2074_6D66;
    localparam logic [31:0] ID_DATA = 32'h6174_6164;
    localparam logic [31:0] ID_JUNK = 32'h4B4E_554A;
    localparam logic [31:0] ID_LIST = 32'h5453_494C;

    localparam int RIFF_HDR_LEN      = 12;
    localparam int FMT_CHUNK_LEN     = 24;
    localparam int FMT_CAPTURE_BYTES = FMT_CHUNK_LEN - 8;
    localparam int FMT_IDX_W         = $clog2(FMT_CAPTURE_BYTES);
    localparam int FMT_CNT_W         = $clog2(FMT_CAPTURE_BYTES + 1);
    localparam int REMAIN_W          = 33;

    // Bytes of the RIFF header that follow its ID.
    localparam logic [REMAIN_W-1:0] RIFF_HDR_REMAIN = REMAIN_W'(RIFF_HDR_LEN - 4);

    typedef enum logic [1:0] {
        CLS_HEADER,
        CLS_FORMAT,
        CLS_DATA,
        CLS_SKIP
    } t_chunk_class;

    typedef enum logic [1:0] {
        END_NONE,
        END_CLEAN,
        END_TRUNC
    } t_end_status;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       is_last;
    } t_in_beat;

    typedef struct packed {
        logic         payload_valid;
        logic [7:0]   payload_byte;
        logic         format_valid;
        logic [15:0]  format_tag;
        logic [15:0]  channel_count;
        logic [31:0]  sample_rate;
        logic [31:0]  byte_rate;
        logic [15:0]  block_align;
        logic [15:0]  bits_per_sample;
        t_chunk_class chunk_class;
        t_end_status  end_status;
    } t_out_beat;

endpackage

/* src/riff_wave_chunk_parser.sv */
`timescale 1ns / 1ps

// WAV stream parser: takes one file byte per beat and returns one result beat for every
// byte, carrying the data payload byte, the captured format fields and the chunk class and
// end-of-file status. The parse step is a single layer of logic from the parser state to one
// output register, so a new byte is accepted every clock whenever the output register is
// empty or is being read in the same cycle; each beat is registered in the cycle after
// its byte is taken, and throughput is one byte per clock while that output register is read.
module riff_wave_chunk_parser
    import rwcp_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_beat  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_beat o_out_data
);

    typedef enum logic [2:0] {
        PH_ID,
        PH_SIZE_SKIP,
        PH_SIZE_FMT,
        PH_SIZE_DATA,
        PH_SKIP,
        PH_FMT,
        PH_DATA,
        PH_RIFFHDR
    } t_phase;

    t_phase                r_phase,       n_phase;
    logic [31:0]           r_id_shift,    n_id_shift;
    logic [1:0]            r_fbi,         n_fbi;
    logic [REMAIN_W-1:0]   r_remain,      n_remain;
    logic [7:0]            r_fmt_bytes [FMT_CAPTURE_BYTES];
    logic [7:0]            n_fmt_bytes [FMT_CAPTURE_BYTES];
    logic                  r_format_seen, n_format_seen;
    logic                  r_pad,         n_pad;
    logic [FMT_CNT_W-1:0]  r_fmt_count,   n_fmt_count;

    logic                  r_out_valid;
    t_out_beat             r_out;
    t_out_beat             n_out;

    logic                  in_fire;
    logic [31:0]           shifted;
    logic [1:0]            fbi_inc;
    logic [REMAIN_W-1:0]   remain_dec;
    logic                  pv;
    t_chunk_class          cls;
    t_end_status           endst;

    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign in_fire     = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign shifted    = {i_in_data.in_byte, r_id_shift[31:8]};
    assign fbi_inc    = r_fbi + 2'd1;
    assign remain_dec = (r_remain != '0) ? r_remain - REMAIN_W'(1) : r_remain;

    always_comb begin
        n_phase       = r_phase;
        n_id_shift    = r_id_shift;
        n_fbi         = r_fbi;
        n_remain      = r_remain;
        n_fmt_bytes   = r_fmt_bytes;
        n_format_seen = r_format_seen;
        n_pad         = r_pad;
        n_fmt_count   = r_fmt_count;
        pv            = 1'b0;
        cls           = CLS_HEADER;

        case (r_phase)
            PH_ID: begin
                n_id_shift = shifted;
                n_fbi      = fbi_inc;
                if (fbi_inc == 2'd0) begin
                    // JUNK, LIST and unknown IDs all fall through to a plain skip.
                    if (shifted == ID_RIFF) begin
                        n_phase  = PH_RIFFHDR;
                        n_remain = RIFF_HDR_REMAIN;
                    end else if (shifted == ID_FMT) begin
                        n_phase = PH_SIZE_FMT;
                    end else if (shifted == ID_DATA) begin
                        n_phase = PH_SIZE_DATA;
                    end else begin
                        n_phase = PH_SIZE_SKIP;
                    end
                    n_id_shift = '0;
                end
            end
            PH_SIZE_SKIP, PH_SIZE_FMT, PH_SIZE_DATA: begin
                n_id_shift = shifted;
                n_fbi      = fbi_inc;
                if (fbi_inc == 2'd0) begin
                    n_id_shift  = '0;
                    n_pad       = shifted[0];
                    n_remain    = {1'b0, shifted} + {{(REMAIN_W-1){1'b0}}, shifted[0]};
                    n_fmt_count = '0;
                    case (r_phase)
                        PH_SIZE_FMT:  n_phase = PH_FMT;
                        PH_SIZE_DATA: n_phase = PH_DATA;
                        default:      n_phase = PH_SKIP;
                    endcase
                    // A zero size is the only case that leaves nothing to count.
                    if (shifted == '0) begin
                        n_phase = PH_ID;
                    end
                end
            end
            PH_SKIP: begin
                cls      = CLS_SKIP;
                n_remain = remain_dec;
                if (remain_dec == '0) n_phase = PH_ID;
            end
            PH_FMT: begin
                cls = CLS_FORMAT;
                if (!r_format_seen && r_fmt_count < FMT_CNT_W'(FMT_CAPTURE_BYTES)) begin
                    n_fmt_bytes[r_fmt_count[FMT_IDX_W-1:0]] = i_in_data.in_byte;
                    n_fmt_count = r_fmt_count + FMT_CNT_W'(1);
                    if (r_fmt_count == FMT_CNT_W'(FMT_CAPTURE_BYTES - 1)) begin
                        n_format_seen = 1'b1;
                    end
                end
                n_remain = remain_dec;
                if (remain_dec == '0) n_phase = PH_ID;
            end
            PH_DATA: begin
                cls = CLS_DATA;
                // The pad byte of an odd data chunk is counted but not passed on.
                pv  = !(r_remain == REMAIN_W'(1) && r_pad);
                n_remain = remain_dec;
                if (remain_dec == '0) n_phase = PH_ID;
            end
            default: begin
                n_remain = remain_dec;
                if (remain_dec == '0) n_phase = PH_ID;
            end
        endcase

        if (!i_in_data.is_last) begin
            endst = END_NONE;
        end else if (n_phase == PH_ID && n_fbi == 2'd0) begin
            endst = END_CLEAN;
        end else begin
            endst = END_TRUNC;
        end

        n_out.payload_valid   = pv;
        n_out.payload_byte    = pv ? i_in_data.in_byte : 8'd0;
        n_out.format_valid    = n_format_seen;
        n_out.format_tag      = {n_fmt_bytes[1], n_fmt_bytes[0]};
        n_out.channel_count   = {n_fmt_bytes[3], n_fmt_bytes[2]};
        n_out.sample_rate     = {n_fmt_bytes[7], n_fmt_bytes[6],
                                 n_fmt_bytes[5], n_fmt_bytes[4]};
        n_out.byte_rate       = {n_fmt_bytes[11], n_fmt_bytes[10],
                                 n_fmt_bytes[9], n_fmt_bytes[8]};
        n_out.block_align     = {n_fmt_bytes[13], n_fmt_bytes[12]};
        n_out.bits_per_sample = {n_fmt_bytes[15], n_fmt_bytes[14]};
        n_out.chunk_class     = cls;
        n_out.end_status      = endst;

        // The last byte of a file returns the parser to its reset state for the next file.
        if (i_in_data.is_last) begin
            n_phase       = PH_ID;
            n_id_shift    = '0;
            n_fbi         = '0;
            n_remain      = '0;
            n_format_seen = 1'b0;
            n_pad         = 1'b0;
            n_fmt_count   = '0;
            for (int k = 0; k < FMT_CAPTURE_BYTES; k++) begin
                n_fmt_bytes[k] = 8'd0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_ID;
            r_id_shift    <= '0;
            r_fbi         <= '0;
            r_remain      <= '0;
            r_format_seen <= 1'b0;
            r_pad         <= 1'b0;
            r_fmt_count   <= '0;
            r_out_valid   <= 1'b0;
            for (int k = 0; k < FMT_CAPTURE_BYTES; k++) begin
                r_fmt_bytes[k] <= 8'd0;
            end
        end else if (in_fire) begin
            r_phase       <= n_phase;
            r_id_shift    <= n_id_shift;
            r_fbi         <= n_fbi;
            r_remain      <= n_remain;
            r_format_seen <= n_format_seen;
            r_pad         <= n_pad;
            r_fmt_count   <= n_fmt_count;
            r_fmt_bytes   <= n_fmt_bytes;
            r_out_valid   <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid   <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_out <= n_out;
        end
    end

    // Payload bytes only ever come from a data chunk.
    a_payload_in_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.payload_valid |-> r_out.chunk_class == CLS_DATA)
        else $error("payload beat outside a data chunk");

    a_payload_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out.payload_valid |-> r_out.payload_byte == 8'd0)
        else $error("payload byte not cleared on a non-payload beat");

    // Waiting for an ID means no chunk bytes are still being counted.
    a_id_no_remain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_ID |-> r_remain == '0)
        else $error("bytes remaining while reading a chunk ID");

    a_fmt_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fmt_count <= FMT_CNT_W'(FMT_CAPTURE_BYTES))
        else $error("format byte count out of range");

    a_last_resets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire && i_in_data.is_last |=>
            r_phase == PH_ID && r_fbi == 2'd0 && !r_format_seen && r_fmt_count == '0)
        else $error("parser state not cleared after the last byte of a file");

endmodule

/* tb/riff_wave_chunk_parser_tb.sv */
`timescale 1ns / 1ps

module riff_wave_chunk_parser_tb;
    import rwcp_pkg::*;

    localparam int CYCLE_LIMIT    = 400000;
    localparam int HALF_ITEMS     = 625;
    localparam int HOLD_AT_RESULT = 600;
    localparam int HOLD_CYCLES    = 400;
    localparam int MAX_GAP        = 13;
    localparam int MAX_BODY       = 700;
    localparam int SETTLE_CYCLES  = 8;
    localparam logic [31:0] FORM_WAVE = 32'h4556_4157;

    typedef enum logic [2:0] {
        ST_ID,
        ST_SIZE_SKIP,
        ST_SIZE_FMT,
        ST_SIZE_DATA,
        ST_SKIP,
        ST_FMT,
        ST_DATA,
        ST_RIFF_HDR
    } t_parse_phase;

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    logic      o_in_ready;
    t_in_beat  i_in_data   = '0;
    logic      o_out_valid;
    logic      i_out_ready = 1'b0;
    t_out_beat o_out_data;

    // Shadow parser state.
    t_parse_phase ph;
    logic [31:0]  id_acc;
    logic [1:0]   field_idx;
    logic [32:0]  bytes_left;
    logic [63:0]  fmt_lo;
    logic [63:0]  fmt_hi;
    logic         fmt_done;
    logic         pad_due;
    logic [4:0]   fmt_cnt;

    t_in_beat    pending_q[$];
    t_out_beat   expected_q[$];
    logic [7:0]  file_q[$];
    bit          body_cut;

    int unsigned n_queued;
    int unsigned n_files;
    int unsigned n_results;
    int unsigned n_errors;
    int unsigned n_payload;
    int unsigned n_format;
    int unsigned n_clean;
    int unsigned n_trunc;
    int unsigned cycles;

    int unsigned send_wait;
    int unsigned recv_wait;
    bit          send_calm;
    bit          recv_calm;

    riff_wave_chunk_parser i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    always #1 i_clk = ~i_clk;

    function automatic void clear_parse_state();
        ph         = ST_ID;
        id_acc     = '0;
        field_idx  = '0;
        bytes_left = '0;
        fmt_lo     = '0;
        fmt_hi     = '0;
        fmt_done   = 1'b0;
        pad_due    = 1'b0;
        fmt_cnt    = '0;
    endfunction

    function automatic void consume_chunk_byte();
        if (bytes_left != '0)
            bytes_left = bytes_left - 33'd1;
        if (bytes_left == '0)
            ph = ST_ID;
    endfunction

    function automatic t_out_beat parse_byte(input t_in_beat beat);
        t_out_beat   res;
        logic [7:0]  b;
        logic [31:0] size;
        b = beat.in_byte;
        res = '0;
        res.chunk_class = CLS_HEADER;
        res.end_status = END_NONE;
        case (ph)
            ST_ID: begin
                id_acc = {b, id_acc[31:8]};
                field_idx = field_idx + 2'd1;
                if (field_idx == 2'd0) begin
                    if (id_acc == ID_RIFF) begin
                        ph = ST_RIFF_HDR;
                        bytes_left = RIFF_HDR_REMAIN;
                    end else if (id_acc == ID_FMT) begin
                        ph = ST_SIZE_FMT;
                    end else if (id_acc == ID_DATA) begin
                        ph = ST_SIZE_DATA;
                    end else begin
                        ph = ST_SIZE_SKIP;
                    end
                    id_acc = '0;
                end
            end
            ST_SIZE_SKIP, ST_SIZE_FMT, ST_SIZE_DATA: begin
                id_acc = {b, id_acc[31:8]};
                field_idx = field_idx + 2'd1;
                if (field_idx == 2'd0) begin
                    size = id_acc;
                    id_acc = '0;
                    pad_due = size[0];
                    bytes_left = {1'b0, size} + 33'(size[0]);
                    fmt_cnt = '0;
                    case (ph)
                        ST_SIZE_FMT: ph = ST_FMT;
                        ST_SIZE_DATA: ph = ST_DATA;
                        default: ph = ST_SKIP;
                    endcase
                    if (bytes_left == '0)
                        ph = ST_ID;
                end
            end
            ST_SKIP: begin
                res.chunk_class = CLS_SKIP;
                consume_chunk_byte();
            end
            ST_FMT: begin
                res.chunk_class = CLS_FORMAT;
                if (!fmt_done && fmt_cnt < FMT_CAPTURE_BYTES) begin
                    if (fmt_cnt < 8)
                        fmt_lo[8*fmt_cnt[2:0] +: 8] = b;
                    else
                        fmt_hi[8*fmt_cnt[2:0] +: 8] = b;
                    fmt_cnt = fmt_cnt + 5'd1;
                    if (fmt_cnt == FMT_CAPTURE_BYTES)
                        fmt_done = 1'b1;
                end
                consume_chunk_byte();
            end
            ST_DATA: begin
                res.chunk_class = CLS_DATA;
                // The pad byte of an odd-sized data chunk is not payload.
                if (!(bytes_left == 33'd1 && pad_due)) begin
                    res.payload_valid = 1'b1;
                    res.payload_byte = b;
                end
                consume_chunk_byte();
            end
            default: begin
                consume_chunk_byte();
            end
        endcase

        if (beat.is_last)
            res.end_status = (ph == ST_ID && field_idx == 2'd0) ? END_CLEAN : END_TRUNC;

        res.format_valid    = fmt_done;
        res.format_tag      = fmt_lo[15:0];
        res.channel_count   = fmt_lo[31:16];
        res.sample_rate     = fmt_lo[63:32];
        res.byte_rate       = fmt_hi[31:0];
        res.block_align     = fmt_hi[47:32];
        res.bits_per_sample = fmt_hi[63:48];

        // The end of a file leaves the parser ready for the next one.
        if (beat.is_last)
            clear_parse_state();
        return res;
    endfunction

    function automatic int unsigned draw_gap(input bit calm);
        return calm ? 0 : $urandom_range(0, MAX_GAP);
    endfunction

    task automatic cmp_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            n_errors++;
        end
    endtask

    // Byte source.
    always @(posedge i_clk) begin
        bit busy;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            send_wait = 0;
        end else begin
            busy = i_in_valid && !o_in_ready;
            if (i_in_valid && o_in_ready) begin
                expected_q.push_back(parse_byte(i_in_data));
                if ($urandom_range(0, 63) == 0)
                    send_calm = !send_calm;
                send_wait = draw_gap(send_calm);
            end
            if (!busy) begin
                if (send_wait == 0 && pending_q.size() != 0) begin
                    i_in_data <= pending_q.pop_front();
                    i_in_valid <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                    if (send_wait != 0)
                        send_wait--;
                end
            end
        end
    end

    // Result sink and checker.
    always @(posedge i_clk) begin
        t_out_beat want;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            recv_wait = 0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                n_results++;
                if (expected_q.size() == 0) begin
                    $error("result beat arrived with no byte outstanding");
                    n_errors++;
                end else begin
                    want = expected_q.pop_front();
                    cmp_field("payload_valid", want.payload_valid, o_out_data.payload_valid);
                    cmp_field("payload_byte", want.payload_byte, o_out_data.payload_byte);
                    cmp_field("format_valid", want.format_valid, o_out_data.format_valid);
                    cmp_field("format_tag", want.format_tag, o_out_data.format_tag);
                    cmp_field("channel_count", want.channel_count, o_out_data.channel_count);
                    cmp_field("sample_rate", want.sample_rate, o_out_data.sample_rate);
                    cmp_field("byte_rate", want.byte_rate, o_out_data.byte_rate);
                    cmp_field("block_align", want.block_align, o_out_data.block_align);
                    cmp_field("bits_per_sample", want.bits_per_sample,
                              o_out_data.bits_per_sample);
                    cmp_field("chunk_class", want.chunk_class, o_out_data.chunk_class);
                    cmp_field("end_status", want.end_status, o_out_data.end_status);
                    if (want.payload_valid)
                        n_payload++;
                    if (want.chunk_class == CLS_FORMAT)
                        n_format++;
                    if (want.end_status == END_CLEAN)
                        n_clean++;
                    if (want.end_status == END_TRUNC)
                        n_trunc++;
                end
                if ($urandom_range(0, 49) == 0)
                    recv_calm = !recv_calm;
                // One long stall lets the output fill and back up the input.
                if (n_results == HOLD_AT_RESULT)
                    recv_wait = HOLD_CYCLES;
                else
                    recv_wait = draw_gap(recv_calm);
            end
            if (recv_wait != 0) begin
                i_out_ready <= 1'b0;
                recv_wait--;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic put_byte(input logic [7:0] b);
        file_q.push_back(b);
    endtask

    task automatic put_word16(input logic [15:0] w);
        put_byte(w[7:0]);
        put_byte(w[15:8]);
    endtask

    task automatic put_word32(input logic [31:0] w);
        put_word16(w[15:0]);
        put_word16(w[31:16]);
    endtask

    task automatic put_riff_hdr();
        put_word32(ID_RIFF);
        put_word32($urandom());
        put_word32(FORM_WAVE);
    endtask

    // A chunk with random body; a huge size is cut short and ends the file.
    task automatic put_chunk(input logic [31:0] id, input logic [31:0] size);
        longint unsigned body;
        put_word32(id);
        put_word32(size);
        body = 64'(size) + 64'(size[0]);
        if (body > MAX_BODY) begin
            body = $urandom_range(0, 40);
            body_cut = 1'b1;
        end
        repeat (body) put_byte($urandom_range(0, 255));
    endtask

    task automatic put_fmt16(input logic [15:0] tag, input logic [15:0] chans,
                             input logic [31:0] rate, input logic [31:0] brate,
                             input logic [15:0] align, input logic [15:0] bits);
        put_word32(ID_FMT);
        put_word32(32'd16);
        put_word16(tag);
        put_word16(chans);
        put_word32(rate);
        put_word32(brate);
        put_word16(align);
        put_word16(bits);
    endtask

    task automatic queue_file();
        t_in_beat beat;
        foreach (file_q[k]) begin
            beat.in_byte = file_q[k];
            beat.is_last = (k == file_q.size() - 1);
            pending_q.push_back(beat);
        end
        n_queued += file_q.size();
        n_files++;
        file_q.delete();
        body_cut = 1'b0;
    endtask

    function automatic logic [31:0] pick_size();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return $urandom_range(0, 20);
        if (r < 90)
            return $urandom_range(21, 100);
        if (r < 97)
            return $urandom_range(101, 600);
        return $urandom();
    endfunction

    // Mostly well-formed files with random content, some noise, some cut short.
    task automatic build_random_file();
        int n_chunks;
        int keep;
        if ($urandom_range(0, 19) == 0) begin
            repeat ($urandom_range(1, 24)) put_byte($urandom_range(0, 255));
        end else begin
            if ($urandom_range(0, 9) != 0)
                put_riff_hdr();
            n_chunks = $urandom_range(1, 5);
            for (int c = 0; c < n_chunks && !body_cut; c++) begin
                case ($urandom_range(0, 9))
                    0, 1: begin
                        case ($urandom_range(0, 9))
                            0, 1, 2, 3, 4: put_chunk(ID_FMT, 32'd16);
                            5, 6: put_chunk(ID_FMT, 32'd18);
                            default: put_chunk(ID_FMT, pick_size());
                        endcase
                    end
                    2, 3, 4: put_chunk(ID_DATA, pick_size());
                    5: put_chunk(ID_JUNK, pick_size());
                    6: put_chunk(ID_LIST, pick_size());
                    7: put_riff_hdr();
                    default: put_chunk($urandom(), pick_size());
                endcase
            end
        end
        if (file_q.size() > 1 && $urandom_range(0, 4) == 0) begin
            keep = $urandom_range(1, file_q.size() - 1);
            while (file_q.size() > keep)
                void'(file_q.pop_back());
        end
        queue_file();
    endtask

    task automatic wait_drained();
        do @(posedge i_clk); while (n_results < n_queued);
    endtask

    initial begin
        int unsigned target;
        clear_parse_state();
        body_cut = 1'b0;
        send_calm = 1'b0;
        recv_calm = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Plain PCM file; data bytes at both extremes, odd size so the file
        // ends on the pad byte.
        put_riff_hdr();
        put_fmt16(16'd1, 16'd2, 32'd44100, 32'd176400, 16'd4, 16'd16);
        put_word32(ID_DATA);
        put_word32(32'd3);
        put_byte(8'h00);
        put_byte(8'hFF);
        put_byte(8'h80);
        put_byte(8'h5A);
        queue_file();

        // Short fmt, zero-size chunk, full fmt with all-ones fields, a later
        // fmt that is not captured, a padded LIST, a RIFF header mid-file, data.
        put_chunk(ID_FMT, 32'd6);
        put_chunk(ID_JUNK, 32'd0);
        put_fmt16(16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF);
        put_chunk(ID_FMT, 32'd18);
        put_chunk(ID_LIST, 32'd3);
        put_riff_hdr();
        put_chunk(ID_DATA, 32'd4);
        queue_file();

        // File ends inside an ID.
        put_byte(ID_DATA[7:0]);
        put_byte(ID_DATA[15:8]);
        queue_file();

        // File ends inside a size field.
        put_word32(ID_DATA);
        put_byte(8'h10);
        put_byte(8'h00);
        queue_file();

        // Largest odd size, cut off inside the payload.
        put_word32(ID_DATA);
        put_word32(32'hFFFF_FFFF);
        repeat (3) put_byte($urandom_range(0, 255));
        queue_file();

        // Ends right after a zero-size data chunk: a clean end.
        put_chunk(ID_DATA, 32'd0);
        queue_file();

        put_byte(8'h00);
        queue_file();
        wait_drained();

        target = n_queued + HALF_ITEMS;
        while (n_queued < target)
            build_random_file();
        wait_drained();

        target = n_queued + HALF_ITEMS;
        while (n_queued < target)
            build_random_file();
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (expected_q.size() != 0) begin
            $error("%0d result beats never arrived", expected_q.size());
            n_errors++;
        end

        $display("Parsed %0d bytes in %0d files: %0d data bytes, %0d format chunk bytes.",
                 n_results, n_files, n_payload, n_format);
        $display("Files ended cleanly %0d times and truncated %0d times; %0d errors.",
                 n_clean, n_trunc, n_errors);
        if (n_errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

/* riff_wave_chunk_parser.f */
src/rwcp_pkg.sv
src/riff_wave_chunk_parser.sv
tb/riff_wave_chunk_parser_tb.sv
